// ===== src/vbd_pkg.sv =====
// Shared types, widths and helpers for the volume backward divergence unit.
// No dependencies; imported by every module of the block.
package vbd_pkg;

	localparam int COMP_W     = 16;
	localparam int TERM_W     = COMP_W + 1;
	localparam int DIV_W      = 19;
	localparam int DIM_W      = 9;
	localparam int DEPTH_CFG_W = 13;
	localparam int SLICE_W    = 12;
	localparam int DEPTH_LIMIT = 4096;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_DEPTH  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic first_x;
		logic last_x;
		logic first_y;
		logic last_y;
		logic first_z;
		logic last_z;
	} axis_flags_t;

	// first -> own, last -> -prev, otherwise own - prev
	function automatic logic signed [TERM_W-1:0] axis_term(
		input logic first,
		input logic last,
		input logic signed [COMP_W-1:0] own,
		input logic signed [COMP_W-1:0] prev
	);
		logic signed [TERM_W-1:0] own_e;
		logic signed [TERM_W-1:0] prev_e;
		own_e  = TERM_W'(own);
		prev_e = TERM_W'(prev);
		if (first) begin
			return own_e;
		end else if (last) begin
			return -prev_e;
		end else begin
			return own_e - prev_e;
		end
	endfunction

endpackage

// ===== src/vbd_mem.sv =====
// Single-port synchronous store, read-first, with registered read data.
// Read data holds while no access is made. Uses vbd_pkg for the data width.
module vbd_mem
	import vbd_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [AW-1:0]            addr,
	input  logic signed [COMP_W-1:0] wdata,
	output logic signed [COMP_W-1:0] rdata
);

	logic signed [COMP_W-1:0] mem [DEPTH];
	logic signed [COMP_W-1:0] rdata_q;

	// read returns the old entry, then it is overwritten with this item
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/vbd_scan.sv =====
// Raster position counters: column, row and slice, with per-axis edge flags
// and store addresses. Uses vbd_pkg for widths and the flag struct.
module vbd_scan
	import vbd_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
	parameter int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
	parameter int PW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic [DIM_W-1:0]       vol_width,
	input  logic [DIM_W-1:0]       vol_height,
	input  logic [DEPTH_CFG_W-1:0] vol_depth,
	output axis_flags_t            flags,
	output logic [CW-1:0]          row_addr,
	output logic [PW-1:0]          plane_addr
);

	localparam int XL = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
	localparam int YL = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [SLICE_W-1:0]     slice_q;
	logic [XL-1:0]          w_in, w_last;
	logic [YL-1:0]          h_in, h_last;
	logic [DEPTH_CFG_W-1:0] d_last;

	// clamp each dimension to [2, max] and take its last index
	always_comb begin
		w_in = XL'(vol_width);
		if (w_in < XL'(2)) begin
			w_last = XL'(1);
		end else if (w_in > XL'(MAX_WIDTH)) begin
			w_last = XL'(MAX_WIDTH - 1);
		end else begin
			w_last = w_in - XL'(1);
		end

		h_in = YL'(vol_height);
		if (h_in < YL'(2)) begin
			h_last = YL'(1);
		end else if (h_in > YL'(MAX_HEIGHT)) begin
			h_last = YL'(MAX_HEIGHT - 1);
		end else begin
			h_last = h_in - YL'(1);
		end

		if (vol_depth < DEPTH_CFG_W'(2)) begin
			d_last = DEPTH_CFG_W'(1);
		end else if (vol_depth > DEPTH_CFG_W'(DEPTH_LIMIT)) begin
			d_last = DEPTH_CFG_W'(DEPTH_LIMIT - 1);
		end else begin
			d_last = vol_depth - DEPTH_CFG_W'(1);
		end
	end

	always_comb begin
		flags.first_x = (col_q == '0);
		flags.last_x  = (XL'(col_q) >= w_last);
		flags.first_y = (row_q == '0);
		flags.last_y  = (YL'(row_q) >= h_last);
		flags.first_z = (slice_q == '0);
		flags.last_z  = (DEPTH_CFG_W'(slice_q) >= d_last);
	end

	assign row_addr   = col_q;
	assign plane_addr = PW'(row_q) * PW'(MAX_WIDTH) + PW'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
		end else if (adv) begin
			if (flags.last_x) begin
				col_q <= '0;
				if (flags.last_y) begin
					row_q   <= '0;
					slice_q <= flags.last_z ? '0 : slice_q + SLICE_W'(1);
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

// ===== src/vbd_calc.sv =====
// Difference stage and output register: sums the three axis terms once the
// store read data is back. Uses vbd_pkg for widths, flags and axis_term.
module vbd_calc
	import vbd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	output logic                     ready,
	input  logic signed [COMP_W-1:0] comp_x,
	input  logic signed [COMP_W-1:0] comp_y,
	input  logic signed [COMP_W-1:0] comp_z,
	input  logic signed [COMP_W-1:0] prev_x,
	input  axis_flags_t              flags,
	input  logic signed [COMP_W-1:0] prev_y,
	input  logic signed [COMP_W-1:0] prev_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DIV_W-1:0]  div_value,
	output logic                     volume_end
);

	logic                     valid_s1;
	logic signed [COMP_W-1:0] cx_s1, cy_s1, cz_s1, px_s1;
	axis_flags_t              flags_s1;
	logic                     out_valid_q;
	logic signed [DIV_W-1:0]  div_q;
	logic                     end_q;
	logic                     adv_s1;
	logic signed [DIV_W-1:0]  sum;

	assign adv_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign ready  = !valid_s1 || adv_s1;

	always_comb begin
		sum = DIV_W'(axis_term(flags_s1.first_x, flags_s1.last_x, cx_s1, px_s1))
		    + DIV_W'(axis_term(flags_s1.first_y, flags_s1.last_y, cy_s1, prev_y))
		    + DIV_W'(axis_term(flags_s1.first_z, flags_s1.last_z, cz_s1, prev_z));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_s1    <= comp_x;
			cy_s1    <= comp_y;
			cz_s1    <= comp_z;
			px_s1    <= prev_x;
			flags_s1 <= flags;
		end
		if (adv_s1) begin
			div_q <= sum;
			end_q <= flags_s1.last_x && flags_s1.last_y && flags_s1.last_z;
		end
	end

	assign out_valid  = out_valid_q;
	assign div_value  = div_q;
	assign volume_end = end_q;

endmodule

// ===== src/volume_backward_divergence_unit.sv =====
// Backward-difference divergence of a 3D vector field, one voxel per item.
// Throughput: one item per cycle while m_tready is high, set by one
// read-first access per cycle on each neighbor store. Reset clears the
// position counters, the previous x component and the pipeline valids
// and sets the dimensions to 256; the row and plane stores are not
// cleared. Depends on vbd_pkg, vbd_scan, vbd_mem and vbd_calc.
module volume_backward_divergence_unit
	import vbd_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,  // comp_x, comp_y, comp_z
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,  // div_value, zero fill
	output logic                   m_tlast,  // volume_end
	input  logic                   wr_en,
	input  logic [1:0]             wr_index,
	input  logic [DEPTH_CFG_W-1:0] wr_data
);

	localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT);

	logic [DIM_W-1:0]         vol_width_q;
	logic [DIM_W-1:0]         vol_height_q;
	logic [DEPTH_CFG_W-1:0]   vol_depth_q;
	logic signed [COMP_W-1:0] prev_x_q;
	logic signed [COMP_W-1:0] comp_x, comp_y, comp_z;
	logic signed [COMP_W-1:0] prev_y, prev_z;
	logic signed [DIV_W-1:0]  div_value;
	axis_flags_t              flags;
	logic [CW-1:0]            row_addr;
	logic [PW-1:0]            plane_addr;
	logic                     accept;

	assign comp_x = s_tdata[COMP_W-1:0];
	assign comp_y = s_tdata[2*COMP_W-1:COMP_W];
	assign comp_z = s_tdata[3*COMP_W-1:2*COMP_W];
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_width_q  <= DIM_W'(256);
			vol_height_q <= DIM_W'(256);
			vol_depth_q  <= DEPTH_CFG_W'(256);
			prev_x_q     <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_WIDTH:  vol_width_q  <= wr_data[DIM_W-1:0];
					REG_HEIGHT: vol_height_q <= wr_data[DIM_W-1:0];
					REG_DEPTH:  vol_depth_q  <= wr_data;
					default:    ;
				endcase
			end
			if (accept) begin
				prev_x_q <= comp_x;
			end
		end
	end

	vbd_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.CW        (CW),
		.RW        (RW),
		.PW        (PW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (accept),
		.vol_width (vol_width_q),
		.vol_height(vol_height_q),
		.vol_depth (vol_depth_q),
		.flags     (flags),
		.row_addr  (row_addr),
		.plane_addr(plane_addr)
	);

	// y neighbor: same column of the previous row
	vbd_mem #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW)
	) u_row_store (
		.clk  (clk),
		.en   (accept),
		.addr (row_addr),
		.wdata(comp_y),
		.rdata(prev_y)
	);

	// z neighbor: same voxel of the previous slice
	vbd_mem #(
		.DEPTH(MAX_WIDTH * MAX_HEIGHT),
		.AW   (PW)
	) u_plane_store (
		.clk  (clk),
		.en   (accept),
		.addr (plane_addr),
		.wdata(comp_z),
		.rdata(prev_z)
	);

	vbd_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.ready     (s_tready),
		.comp_x    (comp_x),
		.comp_y    (comp_y),
		.comp_z    (comp_z),
		.prev_x    (prev_x_q),
		.flags     (flags),
		.prev_y    (prev_y),
		.prev_z    (prev_z),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.div_value (div_value),
		.volume_end(m_tlast)
	);

	assign m_tdata = {{(OUT_DATA_W-DIV_W){1'b0}}, div_value};

endmodule
